// ===== rtl/i2cme_pkg.sv =====
// Package: shared types, codes and the phase timer helper for the I2C master byte engine.
package i2cme_pkg;

    localparam int TickWidth      = 16;
    localparam int CfgIndexWidth  = 1;
    localparam int CfgDataWidth   = 16;

    localparam logic [15:0] LowPhaseReset  = 16'd50;
    localparam logic [15:0] HighPhaseReset = 16'd40;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_LOW_PHASE  = 1'b0,
        CFG_HIGH_PHASE = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START_WAIT = 4'd1,
        PH_START_SET  = 4'd2,
        PH_START_HOLD = 4'd3,
        PH_STOP_WAIT  = 4'd4,
        PH_STOP_SET   = 4'd5,
        PH_STOP_HOLD  = 4'd6,
        PH_BIT_LOW    = 4'd7,
        PH_BIT_RISE   = 4'd8,
        PH_BIT_HIGH   = 4'd9,
        PH_TAIL       = 4'd10
    } phase_t;

    localparam logic [3:0] BitsPerByte = 4'd8;
    localparam logic [7:0] ShiftIdle   = 8'hFF;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       scl_in;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       slave_nack;
    } out_item_t;

    typedef struct packed {
        phase_t                 phase;
        logic [3:0]             bit_count;
        logic [7:0]             shift;
        logic [TickWidth-1:0]   tick_count;
        logic [2:0]             cur_cmd;
        logic                   ack_choice;
        logic [7:0]             rx_byte;
        logic                   nack_flag;
        logic                   scl_drive;
        logic                   sda_drive;
    } engine_state_t;

    typedef struct packed {
        logic                 elapsed;
        logic [TickWidth-1:0] count;
    } timer_t;

    // One tick of a timed phase; a target of zero acts as one.
    function automatic timer_t phase_tick(input logic [TickWidth-1:0] count,
                                          input logic [TickWidth-1:0] target);
        timer_t               res;
        logic [TickWidth-1:0] limit;
        logic [TickWidth-1:0] inc;
        limit = (target == '0) ? TickWidth'(1) : target;
        inc   = count + TickWidth'(1);
        res.elapsed = (inc >= limit);
        res.count   = res.elapsed ? '0 : inc;
        return res;
    endfunction

endpackage

// ===== rtl/i2cme_step.sv =====
// Combinational next-state and result logic for one tick of the I2C master byte engine.
module i2cme_step (
    input  i2cme_pkg::engine_state_t state,
    input  i2cme_pkg::in_item_t      item,
    input  logic [15:0]              low_ticks,
    input  logic [15:0]              high_ticks,
    output i2cme_pkg::engine_state_t state_next,
    output i2cme_pkg::out_item_t     result
);
    import i2cme_pkg::*;

    timer_t     low_t;
    timer_t     high_t;
    logic       done;
    logic [3:0] bits_inc;
    logic [7:0] shift_in;

    assign low_t    = phase_tick(state.tick_count, low_ticks);
    assign high_t   = phase_tick(state.tick_count, high_ticks);
    assign bits_inc = state.bit_count + 4'd1;
    assign shift_in = {state.shift[6:0], item.sda_in};

    always_comb begin
        state_next = state;
        done       = 1'b0;
        unique case (state.phase)
            PH_IDLE: begin
                state_next.tick_count = '0;
                case (item.command)
                    CMD_START: begin
                        state_next.cur_cmd   = item.command;
                        state_next.scl_drive = 1'b0;
                        state_next.phase     = PH_START_WAIT;
                    end
                    CMD_STOP: begin
                        state_next.cur_cmd   = item.command;
                        state_next.sda_drive = 1'b1;
                        state_next.scl_drive = 1'b0;
                        state_next.phase     = PH_STOP_WAIT;
                    end
                    CMD_WRITE: begin
                        state_next.cur_cmd    = item.command;
                        state_next.ack_choice = item.send_ack;
                        state_next.bit_count  = '0;
                        state_next.scl_drive  = 1'b1;
                        state_next.shift      = item.tx_byte;
                        state_next.sda_drive  = ~item.tx_byte[7];
                        state_next.phase      = PH_BIT_LOW;
                    end
                    CMD_READ: begin
                        state_next.cur_cmd    = item.command;
                        state_next.ack_choice = item.send_ack;
                        state_next.bit_count  = '0;
                        state_next.scl_drive  = 1'b1;
                        state_next.shift      = ShiftIdle;
                        state_next.sda_drive  = 1'b0;
                        state_next.phase      = PH_BIT_LOW;
                    end
                    default: ;
                endcase
            end
            PH_START_WAIT: begin
                if (item.scl_in) begin
                    state_next.tick_count = '0;
                    state_next.phase      = PH_START_SET;
                end
            end
            PH_START_SET: begin
                state_next.tick_count = low_t.count;
                if (low_t.elapsed) begin
                    state_next.sda_drive = 1'b1;
                    state_next.phase     = PH_START_HOLD;
                end
            end
            PH_START_HOLD: begin
                state_next.tick_count = high_t.count;
                if (high_t.elapsed) begin
                    state_next.scl_drive = 1'b1;
                    state_next.sda_drive = 1'b0;
                    state_next.phase     = PH_IDLE;
                    done                 = 1'b1;
                end
            end
            PH_STOP_WAIT: begin
                if (item.scl_in) begin
                    state_next.tick_count = '0;
                    state_next.phase      = PH_STOP_SET;
                end
            end
            PH_STOP_SET: begin
                state_next.tick_count = low_t.count;
                if (low_t.elapsed) begin
                    state_next.sda_drive = 1'b0;
                    state_next.phase     = PH_STOP_HOLD;
                end
            end
            PH_STOP_HOLD: begin
                state_next.tick_count = high_t.count;
                if (high_t.elapsed) begin
                    state_next.phase = PH_IDLE;
                    done             = 1'b1;
                end
            end
            PH_BIT_LOW: begin
                state_next.tick_count = low_t.count;
                if (low_t.elapsed) begin
                    state_next.scl_drive = 1'b0;
                    state_next.phase     = PH_BIT_RISE;
                end
            end
            PH_BIT_RISE: begin
                if (item.scl_in) begin
                    state_next.tick_count = '0;
                    state_next.phase      = PH_BIT_HIGH;
                end
            end
            PH_BIT_HIGH: begin
                state_next.tick_count = high_t.count;
                if (high_t.elapsed) begin
                    state_next.shift     = shift_in;
                    state_next.scl_drive = 1'b1;
                    state_next.bit_count = bits_inc;
                    if (bits_inc >= BitsPerByte) begin
                        state_next.phase = PH_TAIL;
                    end else begin
                        // next data bit of a write; reads leave SDA released
                        state_next.sda_drive = (state.cur_cmd == CMD_WRITE) ? ~shift_in[7]
                                                                           : 1'b0;
                        state_next.phase     = PH_BIT_LOW;
                    end
                end
            end
            PH_TAIL: begin
                state_next.tick_count = low_t.count;
                if (low_t.elapsed) begin
                    state_next.shift = ShiftIdle;
                    if (state.bit_count == BitsPerByte) begin
                        // set up the acknowledge bit
                        if (state.cur_cmd == CMD_READ) begin
                            state_next.rx_byte   = state.shift;
                            state_next.sda_drive = state.ack_choice;
                        end else begin
                            state_next.sda_drive = 1'b0;
                        end
                        state_next.phase = PH_BIT_LOW;
                    end else begin
                        if (state.cur_cmd == CMD_WRITE) begin
                            state_next.nack_flag = state.shift[0];
                        end
                        state_next.sda_drive = 1'b0;
                        state_next.phase     = PH_IDLE;
                        done                 = 1'b1;
                    end
                end
            end
            default: begin
                state_next.phase      = PH_IDLE;
                state_next.tick_count = '0;
            end
        endcase
    end

    always_comb begin
        result.scl_pull_low = state_next.scl_drive;
        result.sda_pull_low = state_next.sda_drive;
        result.busy_res     = (state_next.phase != PH_IDLE);
        result.done_res     = done;
        result.rx_byte      = state_next.rx_byte;
        result.slave_nack   = state_next.nack_flag;
    end

endmodule

// ===== rtl/i2c_master_byte_engine_top.sv =====
// Top level: handshakes, configuration registers and engine state of the I2C master byte engine.
//
// I2C master byte engine. Each input transfer is one tick of the bus timebase and carries a
// command (start, stop, write byte, read byte), the byte to send, the ACK choice for a read
// and the sampled SCL and SDA levels. Every accepted tick yields exactly one result transfer
// with the open-drain pull-low controls for SCL and SDA, busy and a one-tick done flag, the
// last received byte and the slave NACK flag of the last write. A command is only taken while
// the engine is idle. Bit timing comes from low_phase_ticks (index 0, reset 50) and
// high_phase_ticks (index 1, reset 40); a value of zero acts as one tick, and the engine waits
// for SCL to read high before timing a high phase, so slaves may stretch the clock. Rate: one
// tick per clock while results are drained. A tick sits in the input register, passes through
// one step of next-state logic as it moves into the result register once the result slot is
// free, and is offered as a result from there; input and output stages keep transfers flowing
// back to back while m_ready stays high.
// Configuration writes are always accepted and must be issued only while the engine is idle.
module i2c_master_byte_engine_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  i2cme_pkg::in_item_t                  s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output i2cme_pkg::out_item_t                 m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [i2cme_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [i2cme_pkg::CfgDataWidth-1:0]   cfg_data
);
    import i2cme_pkg::*;

    logic          in_valid_reg;
    in_item_t      in_item_reg;
    logic          out_valid_reg;
    out_item_t     out_item_reg;
    engine_state_t state_reg;
    engine_state_t state_next;
    out_item_t     step_result;
    logic [15:0]   low_ticks_reg;
    logic [15:0]   high_ticks_reg;
    logic          advance;

    // Tick moves from the input register to the result register when the
    // result slot is free or being drained this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_item_reg;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_ticks_reg  <= LowPhaseReset;
            high_ticks_reg <= HighPhaseReset;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LOW_PHASE:  low_ticks_reg  <= cfg_data;
                CFG_HIGH_PHASE: high_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    i2cme_step u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .low_ticks  (low_ticks_reg),
        .high_ticks (high_ticks_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Engine state advances once per processed tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= PH_IDLE;
            state_reg.bit_count  <= '0;
            state_reg.shift      <= ShiftIdle;
            state_reg.tick_count <= '0;
            state_reg.cur_cmd    <= CMD_NONE;
            state_reg.ack_choice <= 1'b0;
            state_reg.rx_byte    <= '0;
            state_reg.nack_flag  <= 1'b0;
            state_reg.scl_drive  <= 1'b0;
            state_reg.sda_drive  <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= step_result;
        end
    end

endmodule
